### src/deq_pkg.sv
package deq_pkg;

   // fixed field widths of the request and response channels
   localparam int MODE_W  = 3;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   // operation codes; codes above query only act as a query
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_QUERY      = 3'd4
   } mode_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;   // latch the request transaction
      logic exec;     // update pointers, count and write the slot
      logic read;     // read front and back slots
      logic capture;  // load the response register
   } deq_cmd_type;

endpackage

### src/double_ended_queue_top.sv
// double-ended queue in a ring buffer, one response per request transaction
// sequence: request accepted, then exec, slot read and capture; the response is
// valid after capture, which waits until the response register is free
// one transaction at a time: a new request is taken only after the last is captured
// reset: synchronous active high; clears front pointer, count and response valid
// slot contents are not cleared; a response shows slot values only when not empty
module double_ended_queue_top
   import deq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_front_value,
   output logic [VALUE_W-1:0] rsp_back_value,
   output logic [COUNT_W-1:0] rsp_count,
   output logic               rsp_is_empty,
   output logic               rsp_is_full,
   output logic               rsp_error
);

   deq_cmd_type cmd;

   // sequencing of each transaction
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // ring storage, pointers and response register
   deq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_error       (rsp_error)
   );

endmodule

### src/deq_ctrl.sv
module deq_ctrl
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output deq_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_EXEC    = 4'b0010,
      ST_READ    = 4'b0100,
      ST_CAPTURE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // response register may be loaded when empty or drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // no transaction is taken while reset is held
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd.accept  = req_ready && req_valid;
      cmd.exec    = (state_ff == ST_EXEC);
      cmd.read    = (state_ff == ST_READ);
      cmd.capture = (state_ff == ST_CAPTURE) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.capture) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.capture)
      else $error("response register loaded while still pending");

   // each accepted transaction runs exec, read and then waits to capture
   a_sequence: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.exec ##1 cmd.read ##1 (state_ff == ST_CAPTURE))
      else $error("controller left the operation sequence");

   // no new request while an operation is in flight
   a_single_op: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec || cmd.read) |-> !req_ready)
      else $error("request ready during an operation");

endmodule

### src/deq_datapath.sv
module deq_datapath
   import deq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  deq_cmd_type        cmd,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [VALUE_W-1:0] req_value,
   output logic [VALUE_W-1:0] rsp_front_value,
   output logic [VALUE_W-1:0] rsp_back_value,
   output logic [COUNT_W-1:0] rsp_count,
   output logic               rsp_is_empty,
   output logic               rsp_is_full,
   output logic               rsp_error
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = IDX_W + 2;

   // request latch
   logic [MODE_W-1:0]  mode_ff;
   logic [VALUE_W-1:0] value_ff;

   // queue state
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             err_ff, err_in;

   // slot storage and its registered read ports
   logic [DATA_WIDTH-1:0] slots_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_front_ff, rd_back_ff;

   // response register
   logic [VALUE_W-1:0] out_front_ff, out_back_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic               out_empty_ff, out_full_ff, out_err_ff;

   logic                  full, empty;
   logic [IDX_W-1:0]      front_dec, front_inc, tail_idx, back_idx, wr_idx;
   logic [SUM_W-1:0]      tail_sum, last_sum;
   logic                  wr_en;
   logic [DATA_WIDTH+VALUE_W-1:0] value_wide;
   logic [DATA_WIDTH-1:0]         wr_data;
   logic [DATA_WIDTH+VALUE_W-1:0] front_wide, back_wide;
   logic [CNT_W+COUNT_W-1:0]      count_wide;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // ring pointer arithmetic
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign tail_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign tail_idx  = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(tail_sum);
   assign last_sum  = tail_sum - 1'b1;
   assign back_idx  = empty ? front_ff :
                      (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(last_sum);

   // value kept to the storage width
   assign value_wide = {{DATA_WIDTH{1'b0}}, value_ff};
   assign wr_data    = value_wide[DATA_WIDTH-1:0];

   // operation decode
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      err_in   = 1'b0;
      wr_en    = 1'b0;
      wr_idx   = tail_idx;
      case (mode_type'(mode_ff))
         MODE_PUSH_FRONT: begin
            if (full) begin
               err_in = 1'b1;
            end else begin
               front_in = front_dec;
               wr_idx   = front_dec;
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         MODE_PUSH_BACK: begin
            if (full) begin
               err_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               err_in = 1'b1;
            end else begin
               front_in = front_inc;
               count_in = count_ff - 1'b1;
            end
         end
         MODE_POP_BACK: begin
            if (empty) begin
               err_in = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
      end
   end

   // pointer and count update
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) err_ff <= err_in;
   end

   // slot memory, one write and two reads
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) slots_ff[wr_idx] <= wr_data;
      if (cmd.read) begin
         rd_front_ff <= slots_ff[front_ff];
         rd_back_ff  <= slots_ff[back_idx];
      end
   end

   // response formatting
   assign front_wide = {{VALUE_W{1'b0}}, rd_front_ff};
   assign back_wide  = {{VALUE_W{1'b0}}, rd_back_ff};
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         out_front_ff <= empty ? '0 : front_wide[VALUE_W-1:0];
         out_back_ff  <= empty ? '0 : back_wide[VALUE_W-1:0];
         out_count_ff <= count_wide[COUNT_W-1:0];
         out_empty_ff <= empty;
         out_full_ff  <= full;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_front_value = out_front_ff;
   assign rsp_back_value  = out_back_ff;
   assign rsp_count       = out_count_ff;
   assign rsp_is_empty    = out_empty_ff;
   assign rsp_is_full     = out_full_ff;
   assign rsp_error       = out_err_ff;

   // count stays within the ring
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count beyond depth");

   // a refused operation leaves the queue untouched
   a_refused_stable: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && err_in) |=> ($stable(count_ff) && $stable(front_ff)))
      else $error("refused operation changed queue state");

   // an accepted push grows the count by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && wr_en) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not grow the count");

endmodule
